// File: design/tlpf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tlpf_pkg
// shared types and codes for the three-level priority fifo
// ----------------------------------------------------------------------------
package tlpf_pkg;

    // operation codes
    localparam logic [1:0] FUNC_PUSH  = 2'd0;
    localparam logic [1:0] FUNC_POP   = 2'd1;
    localparam logic [1:0] FUNC_CLEAR = 2'd2;

    // status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    // priority levels
    localparam int         LEVELS   = 3;
    localparam logic [1:0] LVL_HIGH = 2'd0;
    localparam logic [1:0] LVL_MED  = 2'd1;
    localparam logic [1:0] LVL_LOW  = 2'd2;
    localparam logic [1:0] LVL_NONE = 2'd3;

    typedef struct packed {
        logic [1:0]         func;
        logic signed [31:0] value;
        logic [1:0]         priority_req;
    } t_in_word;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] out_value;
        logic [1:0]         out_priority;
        logic signed [31:0] head_value;
        logic [1:0]         head_priority;
        logic               empty_flag;
        logic [4:0]         high_count;
        logic [4:0]         medium_count;
        logic [4:0]         low_count;
        logic [5:0]         total_count;
    } t_out_word;

    // controller to datapath commands
    typedef struct packed {
        logic load;     // capture the accepted word
        logic exec;     // apply the operation, issue pop read
        logic head;     // capture popped value, issue head read
        logic resp;     // load the result register
    } t_ctl_cmd;

endpackage
`default_nettype wire

// File: design/tlpf_stream_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tlpf_stream_if
// valid/ready channel carrying one word of a given type
// ----------------------------------------------------------------------------
interface tlpf_stream_if #(
    parameter type t_word = logic
);
    logic  valid;
    logic  ready;
    t_word data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: design/tlpf_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tlpf_ctrl
// sequencer: accept, execute, head read, result hand-off
// ----------------------------------------------------------------------------
module tlpf_ctrl
    import tlpf_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    input  wire logic     i_out_ready,
    output logic          o_in_ready,
    output logic          o_out_valid,
    output t_ctl_cmd      o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_HEAD,
        S_RESP
    } t_state;

    t_state r_state;
    logic   r_in_ready;
    logic   r_out_valid;
    logic   slot_free;

    assign slot_free = !r_out_valid || i_out_ready;

    always_comb begin
        o_cmd.load = (r_state == S_IDLE) && i_in_valid && r_in_ready;
        o_cmd.exec = (r_state == S_EXEC);
        o_cmd.head = (r_state == S_HEAD);
        o_cmd.resp = (r_state == S_RESP) && slot_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_in_ready  <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            // the result step reloads the output itself
            if (r_out_valid && i_out_ready && (r_state != S_RESP)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid && r_in_ready) begin
                        r_state    <= S_EXEC;
                        r_in_ready <= 1'b0;
                    end
                end
                S_EXEC: begin
                    r_state <= S_HEAD;
                end
                S_HEAD: begin
                    r_state <= S_RESP;
                end
                S_RESP: begin
                    if (slot_free) begin
                        r_state     <= S_IDLE;
                        r_in_ready  <= 1'b1;
                        r_out_valid <= 1'b1;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_ready  = r_in_ready;
    assign o_out_valid = r_out_valid;

endmodule
`default_nettype wire

// File: design/tlpf_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tlpf_datapath
// level pointers and counts, shared entry memory, result register
// ----------------------------------------------------------------------------
module tlpf_datapath
    import tlpf_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire t_ctl_cmd  i_cmd,
    input  wire t_in_word  i_word,
    output t_out_word      o_word
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int TW = CW + 2;
    localparam int AW = $clog2(LEVELS * DEPTH);
    localparam int MD = LEVELS * DEPTH;

    logic signed [31:0] r_mem [MD];
    logic [PW-1:0]      r_rp  [LEVELS];
    logic [PW-1:0]      r_wp  [LEVELS];
    logic [CW-1:0]      r_cnt [LEVELS];

    logic [1:0]         r_func;
    logic signed [31:0] r_value;
    logic [1:0]         r_pri;
    logic [1:0]         r_status;
    logic               r_pop_ok;
    logic [1:0]         r_out_pri;
    logic signed [31:0] r_out_value;
    logic signed [31:0] r_rdata;
    t_out_word          r_out_word;

    logic [1:0]         top_lvl;
    logic               push_ok;
    logic               pop_ok;
    logic [AW-1:0]      rd_addr;
    logic [AW-1:0]      wr_addr;
    logic [PW-1:0]      wp_sel;
    logic [TW-1:0]      total;

    function automatic logic [PW-1:0] next_ptr(input logic [PW-1:0] p);
        logic [PW:0] inc;
        inc = {1'b0, p} + (PW+1)'(1);
        return (inc == (PW+1)'(DEPTH)) ? '0 : inc[PW-1:0];
    endfunction

    function automatic logic [AW-1:0] mem_addr(input logic [1:0] lvl,
                                               input logic [PW-1:0] p);
        logic [1:0] l;
        l = (lvl == LVL_NONE) ? LVL_HIGH : lvl;
        return AW'(l) * AW'(DEPTH) + AW'(p);
    endfunction

    // highest non-empty level, none when all are empty
    always_comb begin
        if (r_cnt[0] != '0) begin
            top_lvl = LVL_HIGH;
        end else if (r_cnt[1] != '0) begin
            top_lvl = LVL_MED;
        end else if (r_cnt[2] != '0) begin
            top_lvl = LVL_LOW;
        end else begin
            top_lvl = LVL_NONE;
        end
    end

    always_comb begin
        push_ok = 1'b0;
        wp_sel  = '0;
        for (int l = 0; l < LEVELS; l++) begin
            if (r_pri == 2'(l)) begin
                push_ok = (r_cnt[l] != CW'(DEPTH));
                wp_sel  = r_wp[l];
            end
        end
    end

    assign pop_ok  = (top_lvl != LVL_NONE);
    assign wr_addr = mem_addr(r_pri, wp_sel);

    always_comb begin
        rd_addr = '0;
        for (int l = 0; l < LEVELS; l++) begin
            if (top_lvl == 2'(l)) begin
                rd_addr = mem_addr(top_lvl, r_rp[l]);
            end
        end
    end

    assign total = TW'(r_cnt[0]) + TW'(r_cnt[1]) + TW'(r_cnt[2]);

    // entry memory, one write and one registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && (r_func == FUNC_PUSH) && push_ok) begin
            r_mem[wr_addr] <= r_value;
        end
        if (i_cmd.exec || i_cmd.head) begin
            r_rdata <= r_mem[rd_addr];
        end
    end

    // pointers and counts
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int l = 0; l < LEVELS; l++) begin
                r_rp[l]  <= '0;
                r_wp[l]  <= '0;
                r_cnt[l] <= '0;
            end
        end else if (i_cmd.exec) begin
            case (r_func)
                FUNC_PUSH: begin
                    for (int l = 0; l < LEVELS; l++) begin
                        if (push_ok && (r_pri == 2'(l))) begin
                            r_wp[l]  <= next_ptr(r_wp[l]);
                            r_cnt[l] <= r_cnt[l] + CW'(1);
                        end
                    end
                end
                FUNC_POP: begin
                    for (int l = 0; l < LEVELS; l++) begin
                        if (top_lvl == 2'(l)) begin
                            r_rp[l]  <= next_ptr(r_rp[l]);
                            r_cnt[l] <= r_cnt[l] - CW'(1);
                        end
                    end
                end
                FUNC_CLEAR: begin
                    for (int l = 0; l < LEVELS; l++) begin
                        r_rp[l]  <= '0;
                        r_wp[l]  <= '0;
                        r_cnt[l] <= '0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // operation word and result fields
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func  <= i_word.func;
            r_value <= i_word.value;
            r_pri   <= i_word.priority_req;
        end
        if (i_cmd.exec) begin
            r_pop_ok  <= (r_func == FUNC_POP) && pop_ok;
            r_out_pri <= ((r_func == FUNC_POP) && pop_ok) ? top_lvl : LVL_HIGH;
            case (r_func)
                FUNC_PUSH: begin
                    r_status <= push_ok ? ST_OK : ST_FULL;
                end
                FUNC_POP: begin
                    r_status <= pop_ok ? ST_OK : ST_EMPTY;
                end
                default: begin
                    r_status <= ST_OK;
                end
            endcase
        end
        if (i_cmd.head) begin
            r_out_value <= r_pop_ok ? r_rdata : 32'sd0;
        end
        if (i_cmd.resp) begin
            r_out_word.status        <= r_status;
            r_out_word.out_value     <= r_out_value;
            r_out_word.out_priority  <= r_out_pri;
            r_out_word.head_value    <= pop_ok ? r_rdata : 32'sd0;
            r_out_word.head_priority <= pop_ok ? top_lvl : LVL_HIGH;
            r_out_word.empty_flag    <= (total == '0);
            r_out_word.high_count    <= 5'(r_cnt[0]);
            r_out_word.medium_count  <= 5'(r_cnt[1]);
            r_out_word.low_count     <= 5'(r_cnt[2]);
            r_out_word.total_count   <= 6'(total);
        end
    end

    assign o_word = r_out_word;

endmodule
`default_nettype wire

// File: design/three_level_priority_fifo_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// three_level_priority_fifo_top
// strict three-level priority queue, first-in first-out within each level
//
//   channel   dir   word          contents
//   i_in      in    t_in_word     func, value, priority_req
//   o_out     out   t_out_word    status, removed item, head, level counts
//
// each word passes through accept, execute (push write or pop read),
// head read and result load; the single read port of the entry memory
// makes the pop value and the new head two reads in turn
// reset is synchronous and active low; it empties all levels at once,
// the entry memory itself is not cleared
// a stalled result holds the sequencer in its last step; the next word
// is taken while a finished result still waits in the output register
// ----------------------------------------------------------------------------
module three_level_priority_fifo_top
    import tlpf_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    tlpf_stream_if.sink   i_in,
    tlpf_stream_if.source o_out
);

    t_ctl_cmd cmd;

    // sequencer
    tlpf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_out_ready (o_out.ready),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .o_cmd       (cmd)
    );

    // pointers, counts, entry memory and result register
    tlpf_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .i_word  (i_in.data),
        .o_word  (o_out.data)
    );

    // one word in flight: no second accept straight after the first
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> !i_in.ready)
        else $error("word accepted while another is in flight");

    // an empty queue reports a zero head
    a_empty_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.data.empty_flag) |->
            (o_out.data.head_value == 32'sd0 && o_out.data.head_priority == LVL_HIGH))
        else $error("head reported on empty queue");

    // a refused or failed operation removes nothing
    a_no_removal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.data.status != ST_OK) |->
            (o_out.data.out_value == 32'sd0 && o_out.data.out_priority == LVL_HIGH))
        else $error("removed item reported on a failed operation");

    // pop on empty leaves the queue empty
    a_empty_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.data.status == ST_EMPTY) |-> o_out.data.empty_flag)
        else $error("pop on empty reported a non-empty queue");

endmodule
`default_nettype wire
